// ===== rtl/pncm_pkg.sv =====
// Package with shared constants and types for the plane normal cluster match block.
`default_nettype none
package pncm_pkg;
  localparam int MAX_CLUSTERS_DEF = 256;
  localparam int KEY_W = 54;
  localparam int PART_W = 18;
  localparam logic [15:0] QUANT_STEP_RST = 16'd655;
  localparam logic [31:0] CENTER_LIMIT_RST = 32'hFFFE8000;
  localparam logic [0:0] REG_QUANT_STEP = 1'b0;
  localparam logic [0:0] REG_CENTER_LIMIT = 1'b1;

  typedef struct packed {
    logic load;
    logic sqrt_go;
    logic div_go;
    logic [1:0] div_sel;
    logic qdiv_go;
    logic [1:0] qdiv_sel;
    logic search_clr;
    logic search_step;
    logic append;
    logic emit;
  } ctrl_t;

  typedef struct packed {
    logic sqrt_done;
    logic div_done;
    logic search_match;
    logic search_end;
    logic table_full;
    logic join_ok;
  } stat_t;
endpackage
`default_nettype wire

// ===== rtl/pncm_ram.sv =====
// Generic single-port RAM with registered read.
`default_nettype none
module pncm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule
`default_nettype wire

// ===== rtl/pncm_datapath.sv =====
// Datapath: square root, shared divider, key store and search.
`default_nettype none
module pncm_datapath #(
  parameter int MAX_CLUSTERS = pncm_pkg::MAX_CLUSTERS_DEF
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire pncm_pkg::ctrl_t ctrl,
  output pncm_pkg::stat_t      stat,
  input  wire logic [31:0]     slope_x,
  input  wire logic [31:0]     slope_y,
  input  wire logic [31:0]     center_y,
  input  wire logic [15:0]     quant_step,
  input  wire logic [31:0]     center_limit,
  output logic [7:0]           cluster_index,
  output logic                 is_new,
  output logic                 table_full,
  output logic [17:0]          norm_x,
  output logic [17:0]          norm_y,
  output logic [16:0]          norm_z,
  output logic                 out_valid
);
  localparam int AW = $clog2(MAX_CLUSTERS);
  localparam int CW = AW + 1;
  localparam int KW = pncm_pkg::KEY_W;
  localparam int PW = pncm_pkg::PART_W;

  logic [31:0] a_r, b_r, cy_r;
  logic [31:0] ua, ub;
  logic [63:0] sq_a, sq_b;
  logic [64:0] s_sum;

  // Multiplier results are registered before the sum.
  logic [63:0] sqa_r, sqb_r;
  logic [1:0]  mul_ph_r;

  // Restoring square root, one result bit per cycle.
  logic [65:0] sq_rem_r, sq_rem_nxt;
  logic [64:0] sq_val_r;
  logic [32:0] sq_root_r;
  logic [5:0]  sq_cnt_r;
  logic        sq_busy_r;
  logic [67:0] sq_trial;

  // Shared restoring divider, one quotient bit per cycle.
  logic [48:0] dv_num_r;
  logic [32:0] dv_den_r;
  logic [33:0] dv_rem_r;
  logic [48:0] dv_quo_r;
  logic [5:0]  dv_cnt_r;
  logic        dv_busy_r;
  logic        dv_neg_r;
  logic [33:0] dv_shift;
  logic [33:0] dv_diff;

  logic [17:0] nx_r, ny_r;
  logic [16:0] nz_r;
  logic [PW-1:0] kx_r, ky_r, kz_r;
  logic [KW-1:0] key;
  logic [CW-1:0] count_r;
  logic [CW-1:0] sidx_r;
  logic          match_r;
  logic [AW-1:0] ram_addr;
  logic [KW-1:0] ram_rdata;
  logic          rd_valid_r;
  logic [15:0]   q_eff;
  logic [48:0]   dv_in_num;
  logic [32:0]   dv_in_den;
  logic          dv_in_neg;
  logic [17:0]   dv_res;
  logic [16:0]   nz_mag;

  assign ua = a_r[31] ? (32'd0 - a_r) : a_r;
  assign ub = b_r[31] ? (32'd0 - b_r) : b_r;
  assign sq_a = ua * ua;
  assign sq_b = ub * ub;
  assign s_sum = {1'b0, sqa_r} + {1'b0, sqb_r} + 65'h1_0000_0000;
  assign q_eff = (quant_step == 16'd0) ? 16'd1 : quant_step;

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      a_r  <= slope_x;
      b_r  <= slope_y;
      cy_r <= center_y;
    end
    sqa_r <= sq_a;
    sqb_r <= sq_b;
  end

  assign sq_trial = {sq_rem_r, sq_val_r[64:63]} - {1'b0, 32'd0, sq_root_r, 2'b01};
  always_comb begin
    sq_rem_nxt = sq_trial[67] ? {sq_rem_r[63:0], sq_val_r[64:63]} : sq_trial[65:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sq_busy_r <= 1'b0;
      mul_ph_r  <= 2'd0;
    end else if (ctrl.sqrt_go) begin
      mul_ph_r  <= 2'd2;
      sq_busy_r <= 1'b0;
    end else if (mul_ph_r != 2'd0) begin
      mul_ph_r <= mul_ph_r - 2'd1;
      if (mul_ph_r == 2'd1) begin
        // The sum is below 2^64, so its 32 bit pairs are taken from the top.
        sq_val_r  <= {s_sum[63:0], 1'b0};
        sq_rem_r  <= 66'd0;
        sq_root_r <= 33'd0;
        sq_cnt_r  <= 6'd32;
        sq_busy_r <= 1'b1;
      end
    end else if (sq_busy_r) begin
      sq_rem_r  <= sq_rem_nxt;
      sq_root_r <= {sq_root_r[31:0], ~sq_trial[67]};
      sq_val_r  <= {sq_val_r[62:0], 2'b00};
      sq_cnt_r  <= sq_cnt_r - 6'd1;
      if (sq_cnt_r == 6'd1) begin
        sq_busy_r <= 1'b0;
      end
    end
  end
  assign stat.sqrt_done = !sq_busy_r && (mul_ph_r == 2'd0);

  always_comb begin
    dv_in_num = 49'd0;
    dv_in_den = sq_root_r;
    dv_in_neg = 1'b0;
    if (ctrl.div_go) begin
      case (ctrl.div_sel)
        2'd0: begin
          dv_in_num = {1'b0, ua, 16'd0};
          dv_in_neg = a_r[31];
        end
        2'd1: begin
          dv_in_num = {1'b0, ub, 16'd0};
          dv_in_neg = b_r[31];
        end
        default: begin
          dv_in_num = 49'h1_0000_0000;
        end
      endcase
    end else begin
      dv_in_den = {17'd0, q_eff};
      case (ctrl.qdiv_sel)
        2'd0: begin
          dv_in_num = {32'd0, nx_r[17] ? 17'(18'd0 - nx_r) : nx_r[16:0]};
          dv_in_neg = nx_r[17];
        end
        2'd1: begin
          dv_in_num = {32'd0, ny_r[17] ? 17'(18'd0 - ny_r) : ny_r[16:0]};
          dv_in_neg = ny_r[17];
        end
        default: begin
          dv_in_num = {32'd0, 17'(17'd0 - nz_r)};
          dv_in_neg = 1'b1;
        end
      endcase
    end
  end

  assign dv_shift = {dv_rem_r[32:0], dv_num_r[48]};
  assign dv_diff = dv_shift - {1'b0, dv_den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dv_busy_r <= 1'b0;
    end else if (ctrl.div_go || ctrl.qdiv_go) begin
      dv_num_r  <= dv_in_num;
      dv_den_r  <= dv_in_den;
      dv_neg_r  <= dv_in_neg;
      dv_rem_r  <= 34'd0;
      dv_quo_r  <= 49'd0;
      dv_cnt_r  <= 6'd49;
      dv_busy_r <= 1'b1;
    end else if (dv_busy_r) begin
      dv_num_r <= {dv_num_r[47:0], 1'b0};
      if (!dv_diff[33]) begin
        dv_rem_r <= dv_diff;
        dv_quo_r <= {dv_quo_r[47:0], 1'b1};
      end else begin
        dv_rem_r <= dv_shift;
        dv_quo_r <= {dv_quo_r[47:0], 1'b0};
      end
      dv_cnt_r <= dv_cnt_r - 6'd1;
      if (dv_cnt_r == 6'd1) begin
        dv_busy_r <= 1'b0;
      end
    end
  end
  assign stat.div_done = !dv_busy_r;
  // Quotient magnitudes stay within 2^16, so 18 bits hold the signed result.
  assign dv_res = dv_neg_r ? (18'd0 - dv_quo_r[17:0]) : dv_quo_r[17:0];
  assign nz_mag = dv_quo_r[16:0];

  logic [1:0] wr_sel_r;
  logic       wr_div_r, wr_q_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_div_r <= 1'b0;
      wr_q_r   <= 1'b0;
    end else begin
      if (ctrl.div_go) begin
        wr_div_r <= 1'b1;
        wr_q_r   <= 1'b0;
        wr_sel_r <= ctrl.div_sel;
      end else if (ctrl.qdiv_go) begin
        wr_div_r <= 1'b0;
        wr_q_r   <= 1'b1;
        wr_sel_r <= ctrl.qdiv_sel;
      end else if (!dv_busy_r) begin
        wr_div_r <= 1'b0;
        wr_q_r   <= 1'b0;
      end
    end
  end
  always_ff @(posedge clk) begin
    if (!dv_busy_r && wr_div_r) begin
      case (wr_sel_r)
        2'd0: nx_r <= dv_res;
        2'd1: ny_r <= dv_res;
        default: nz_r <= 17'd0 - nz_mag;
      endcase
    end
    if (!dv_busy_r && wr_q_r) begin
      case (wr_sel_r)
        2'd0: kx_r <= dv_res;
        2'd1: ky_r <= dv_res;
        default: kz_r <= dv_res;
      endcase
    end
  end

  assign key = {kx_r, ky_r, kz_r};

  // The RAM read of entry sidx_r is registered and returns in the next cycle.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r    <= '0;
      rd_valid_r <= 1'b0;
      match_r    <= 1'b0;
    end else begin
      if (ctrl.search_clr) begin
        sidx_r     <= '0;
        rd_valid_r <= 1'b0;
        match_r    <= 1'b0;
      end else if (ctrl.search_step) begin
        if (rd_valid_r && ram_rdata == key) begin
          match_r <= 1'b1;
        end else if (rd_valid_r) begin
          sidx_r     <= sidx_r + CW'(1);
          rd_valid_r <= 1'b0;
        end else begin
          rd_valid_r <= 1'b1;
        end
      end
      if (ctrl.append && count_r != CW'(MAX_CLUSTERS)) begin
        count_r <= count_r + CW'(1);
      end
    end
  end

  assign ram_addr = ctrl.append ? count_r[AW-1:0] : sidx_r[AW-1:0];
  assign stat.search_match = match_r;
  assign stat.search_end = (sidx_r >= count_r);
  assign stat.table_full = (count_r == CW'(MAX_CLUSTERS));
  assign stat.join_ok = $signed(cy_r) > $signed(center_limit);

  pncm_ram #(.WIDTH(KW), .DEPTH(MAX_CLUSTERS)) u_keys (
    .clk   (clk),
    .we    (ctrl.append && count_r != CW'(MAX_CLUSTERS)),
    .addr  (ram_addr),
    .wdata (key),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= ctrl.emit;
    end
    if (ctrl.emit) begin
      norm_x <= nx_r;
      norm_y <= ny_r;
      norm_z <= nz_r;
      if (match_r && stat.join_ok) begin
        cluster_index <= 8'(sidx_r);
        is_new        <= 1'b0;
        table_full    <= 1'b0;
      end else if (stat.table_full) begin
        cluster_index <= 8'd0;
        is_new        <= 1'b0;
        table_full    <= 1'b1;
      end else begin
        cluster_index <= 8'(count_r);
        is_new        <= 1'b1;
        table_full    <= 1'b0;
      end
    end
  end
endmodule
`default_nettype wire

// ===== rtl/pncm_ctrl.sv =====
// Controller state machine sequencing root, divisions, search and append.
`default_nettype none
module pncm_ctrl (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            start,
  output logic                 busy,
  input  wire pncm_pkg::stat_t stat,
  output pncm_pkg::ctrl_t      ctrl
);
  typedef enum logic [9:0] {
    S_IDLE   = 10'b0000000001,
    S_SQRT   = 10'b0000000010,
    S_SQWAIT = 10'b0000000100,
    S_DIV    = 10'b0000001000,
    S_DWAIT  = 10'b0000010000,
    S_QDIV   = 10'b0000100000,
    S_QWAIT  = 10'b0001000000,
    S_SEARCH = 10'b0010000000,
    S_EMIT   = 10'b0100000000,
    S_DONE   = 10'b1000000000
  } state_t;

  state_t state_r, state_nxt;
  logic [1:0] sel_r, sel_nxt;
  logic       first_r, first_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      sel_r   <= 2'd0;
      first_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      sel_r   <= sel_nxt;
      first_r <= first_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    sel_nxt   = sel_r;
    first_nxt = 1'b0;
    ctrl      = '0;
    ctrl.div_sel  = sel_r;
    ctrl.qdiv_sel = sel_r;
    busy      = 1'b1;
    case (state_r)
      S_IDLE: begin
        busy = 1'b0;
        if (start) begin
          ctrl.load = 1'b1;
          state_nxt = S_SQRT;
        end
      end
      S_SQRT: begin
        ctrl.sqrt_go = 1'b1;
        first_nxt = 1'b1;
        state_nxt = S_SQWAIT;
      end
      S_SQWAIT: begin
        if (stat.sqrt_done && !first_r) begin
          sel_nxt   = 2'd0;
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        ctrl.div_go = 1'b1;
        first_nxt = 1'b1;
        state_nxt = S_DWAIT;
      end
      S_DWAIT: begin
        if (stat.div_done && !first_r) begin
          if (sel_r == 2'd2) begin
            sel_nxt   = 2'd0;
            state_nxt = S_QDIV;
          end else begin
            sel_nxt   = sel_r + 2'd1;
            state_nxt = S_DIV;
          end
        end
      end
      S_QDIV: begin
        ctrl.qdiv_go = 1'b1;
        first_nxt = 1'b1;
        state_nxt = S_QWAIT;
      end
      S_QWAIT: begin
        if (stat.div_done && !first_r) begin
          if (sel_r == 2'd2) begin
            ctrl.search_clr = 1'b1;
            first_nxt = 1'b1;
            state_nxt = S_SEARCH;
          end else begin
            sel_nxt   = sel_r + 2'd1;
            state_nxt = S_QDIV;
          end
        end
      end
      S_SEARCH: begin
        // The search waits while first_r is set, letting the key registers settle after the last quotient write.
        if (!first_r) begin
          if (stat.search_match || stat.search_end) begin
            state_nxt = S_EMIT;
          end else begin
            ctrl.search_step = 1'b1;
          end
        end
      end
      S_EMIT: begin
        ctrl.emit = 1'b1;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        ctrl.append = !(stat.search_match && stat.join_ok);
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end
endmodule
`default_nettype wire

// ===== rtl/plane_normal_cluster_match_top.sv =====
// Top level of the plane normal cluster match block.
// One segment keeps busy high through a square root and six divisions on one shared
// divider, then a search that reads and compares the stored keys one at a time, because
// the key RAM has a single registered read port. The next start is taken only while
// busy is low. The result beat is on the out_ ports, marked by out_valid in the last
// cycle of busy, high for exactly one cycle; the receiver cannot hold it off and must
// take it in that cycle.
`default_nettype none
module plane_normal_cluster_match_top #(
  parameter int MAX_CLUSTERS = pncm_pkg::MAX_CLUSTERS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [31:0] in_slope_x,
  input  wire logic [31:0] in_slope_y,
  input  wire logic [31:0] in_center_y,
  output logic             out_valid,
  output logic [7:0]       out_cluster_index,
  output logic             out_is_new,
  output logic             out_table_full,
  output logic [17:0]      out_norm_x,
  output logic [17:0]      out_norm_y,
  output logic [16:0]      out_norm_z,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);
  pncm_pkg::ctrl_t ctrl;
  pncm_pkg::stat_t stat;
  logic [15:0] quant_step_r;
  logic [31:0] center_limit_r;
  logic        wr;

  assign pready = 1'b1;
  assign wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      quant_step_r   <= pncm_pkg::QUANT_STEP_RST;
      center_limit_r <= pncm_pkg::CENTER_LIMIT_RST;
    end else if (wr && paddr[1:0] == 2'b00) begin
      if (paddr[2] == pncm_pkg::REG_QUANT_STEP) begin
        quant_step_r <= pwdata[15:0];
      end else begin
        center_limit_r <= pwdata;
      end
    end
  end

  always_comb begin
    prdata = 32'd0;
    if (paddr[1:0] == 2'b00) begin
      if (paddr[2] == pncm_pkg::REG_CENTER_LIMIT) begin
        prdata = center_limit_r;
      end else begin
        prdata = {16'd0, quant_step_r};
      end
    end
  end

  pncm_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .stat  (stat),
    .ctrl  (ctrl)
  );

  pncm_datapath #(.MAX_CLUSTERS(MAX_CLUSTERS)) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .ctrl          (ctrl),
    .stat          (stat),
    .slope_x       (in_slope_x),
    .slope_y       (in_slope_y),
    .center_y      (in_center_y),
    .quant_step    (quant_step_r),
    .center_limit  (center_limit_r),
    .cluster_index (out_cluster_index),
    .is_new        (out_is_new),
    .table_full    (out_table_full),
    .norm_x        (out_norm_x),
    .norm_y        (out_norm_y),
    .norm_z        (out_norm_z),
    .out_valid     (out_valid)
  );

`ifndef SYNTHESIS
  a_new_full_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_is_new && out_table_full))
    else $error("new and full flags both set");
  a_valid_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> busy)
    else $error("result beat without busy");
  a_nz_nonpos: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_norm_z[16] || out_norm_z == 17'd0))
    else $error("positive z component");
`endif
endmodule
`default_nettype wire

// ===== verif/plane_normal_cluster_match_checker.sv =====
// Checker that predicts and compares the cluster match results of the block.
`timescale 1ns / 1ps
module plane_normal_cluster_match_checker #(
  parameter int MAX_CLUSTERS = pncm_pkg::MAX_CLUSTERS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic        busy,
  input  logic [31:0] in_slope_x,
  input  logic [31:0] in_slope_y,
  input  logic [31:0] in_center_y,
  input  logic        out_valid,
  input  logic [7:0]  out_cluster_index,
  input  logic        out_is_new,
  input  logic        out_table_full,
  input  logic [17:0] out_norm_x,
  input  logic [17:0] out_norm_y,
  input  logic [16:0] out_norm_z,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic        pready,
  output int          fail_count,
  output int          pending
);
  typedef struct packed {
    logic [7:0]  cluster_index;
    logic        is_new;
    logic        table_full;
    logic [17:0] norm_x;
    logic [17:0] norm_y;
    logic [16:0] norm_z;
  } match_t;

  match_t                     match_q[$];
  logic [pncm_pkg::KEY_W-1:0] cluster_keys[MAX_CLUSTERS];
  int                         key_count;
  logic [15:0]                quant_step;
  logic [31:0]                center_limit;

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned res;
    longint unsigned bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v = v - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  function automatic match_t match_segment(logic [31:0] sx, logic [31:0] sy, logic [31:0] cy);
    longint a, b, cyv, lim, q, r, nx, ny, nz;
    longint unsigned ua, ub, s;
    logic [pncm_pkg::KEY_W-1:0] key;
    logic [pncm_pkg::PART_W-1:0] kx, ky, kz;
    int idx;
    bit found;
    match_t m;
    a = longint'($signed(sx));
    b = longint'($signed(sy));
    cyv = longint'($signed(cy));
    lim = longint'($signed(center_limit));
    q = (quant_step == 0) ? 1 : longint'(quant_step);
    ua = (a < 0) ? -a : a;
    ub = (b < 0) ? -b : b;
    s = ua * ua + ub * ub + (64'd1 << 32);
    r = longint'(int_sqrt(s));
    nx = (a * 65536) / r;
    ny = (b * 65536) / r;
    nz = -longint'((64'd1 << 32) / r);
    kx = pncm_pkg::PART_W'(nx / q);
    ky = pncm_pkg::PART_W'(ny / q);
    kz = pncm_pkg::PART_W'(nz / q);
    key = {kx, ky, kz};
    idx = 0;
    found = 0;
    for (int i = 0; i < key_count; i++) begin
      if (!found && cluster_keys[i] == key) begin
        found = 1;
        idx = i;
      end
    end
    m = '0;
    if (!(found && cyv > lim)) begin
      if (key_count >= MAX_CLUSTERS) begin
        m.table_full = 1'b1;
        idx = 0;
      end else begin
        idx = key_count;
        cluster_keys[key_count] = key;
        key_count++;
        m.is_new = 1'b1;
      end
    end
    m.cluster_index = 8'(idx);
    m.norm_x = 18'(nx);
    m.norm_y = 18'(ny);
    m.norm_z = 17'(nz);
    return m;
  endfunction

  assign pending = match_q.size();

  always @(posedge clk) begin
    match_t e;
    if (!rst_n) begin
      key_count = 0;
      quant_step = pncm_pkg::QUANT_STEP_RST;
      center_limit = pncm_pkg::CENTER_LIMIT_RST;
      fail_count = 0;
      match_q.delete();
    end else begin
      if (out_valid) begin
        if (match_q.size() == 0) begin
          $display("%0t: unexpected result beat, index %0d", $time, out_cluster_index);
          fail_count++;
        end else begin
          e = match_q.pop_front();
          if (out_cluster_index !== e.cluster_index || out_is_new !== e.is_new ||
              out_table_full !== e.table_full || out_norm_x !== e.norm_x ||
              out_norm_y !== e.norm_y || out_norm_z !== e.norm_z) begin
            $display("%0t: mismatch expected idx=%0d new=%b full=%b n=(%h %h %h)", $time,
                     e.cluster_index, e.is_new, e.table_full, e.norm_x, e.norm_y, e.norm_z);
            $display("%0t:          actual   idx=%0d new=%b full=%b n=(%h %h %h)", $time,
                     out_cluster_index, out_is_new, out_table_full, out_norm_x, out_norm_y,
                     out_norm_z);
            fail_count++;
          end
        end
      end
      if (start && !busy) begin
        match_q.insert(match_q.size(), match_segment(in_slope_x, in_slope_y, in_center_y));
      end
      if (psel && penable && pwrite && pready) begin
        if (paddr[2] == pncm_pkg::REG_QUANT_STEP) quant_step = pwdata[15:0];
        else center_limit = pwdata;
      end
    end
  end
endmodule

// ===== verif/tb_plane_normal_cluster_match_top.sv =====
// Testbench top that drives segments and register writes into the cluster match block.
`timescale 1ns / 1ps
module tb_plane_normal_cluster_match_top;
  logic        clk = 0;
  logic        rst_n = 0;
  logic        start = 0;
  logic        busy;
  logic [31:0] in_slope_x = 0, in_slope_y = 0, in_center_y = 0;
  logic        out_valid, out_is_new, out_table_full;
  logic [7:0]  out_cluster_index;
  logic [17:0] out_norm_x, out_norm_y;
  logic [16:0] out_norm_z;
  logic        psel = 0, penable = 0, pwrite = 0;
  logic [2:0]  paddr = 0;
  logic [31:0] pwdata = 0;
  logic [31:0] prdata;
  logic        pready;
  int          fail_count, pending;
  int          idle_pct;
  logic [31:0] slope_pool[8];

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  plane_normal_cluster_match_top uut (.*);

  plane_normal_cluster_match_checker chk (.*);

  task automatic write_reg(logic [0:0] idx, logic [31:0] value);
    @(negedge clk);
    psel = 1; penable = 0; pwrite = 1; paddr = {idx, 2'b00}; pwdata = value;
    @(negedge clk);
    penable = 1;
    @(negedge clk);
    psel = 0; penable = 0; pwrite = 0;
  endtask

  task automatic send_segment(logic [31:0] sx, logic [31:0] sy, logic [31:0] cy);
    @(negedge clk);
    while (busy || ($urandom_range(0, 99) < idle_pct)) @(negedge clk);
    start = 1; in_slope_x = sx; in_slope_y = sy; in_center_y = cy;
    @(negedge clk);
    start = 0;
  endtask

  task automatic drain();
    @(negedge clk);
    while (pending != 0 || busy) @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  function automatic logic [31:0] pick_slope();
    case ($urandom_range(0, 3))
      0: return slope_pool[$urandom_range(0, 7)];
      1: return $urandom();
      2: return 32'($urandom_range(0, 32'h3FFFF)) - 32'h20000;
      default: return $urandom_range(0, 1) ? 32'h7FFFFFFF : 32'h80000000;
    endcase
  endfunction

  initial begin
    logic [31:0] sx, sy;
    idle_pct = 0;
    foreach (slope_pool[i]) slope_pool[i] = 32'($urandom_range(0, 32'h3FFFF)) - 32'h20000;
    repeat (2) @(negedge clk);
    rst_n = 1;

    send_segment(32'h0, 32'h0, 32'h0);
    send_segment(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF);
    send_segment(32'h80000000, 32'h80000000, 32'h80000000);
    send_segment(32'h7FFFFFFF, 32'h80000000, 32'h0);
    send_segment(32'h00010000, 32'hFFFF0000, 32'h0);
    send_segment(32'h00010000, 32'hFFFF0000, 32'hFFFE8001);
    send_segment(32'h00010000, 32'hFFFF0000, 32'hFFFE8000);
    send_segment(32'h00010000, 32'hFFFF0000, 32'h80000000);
    send_segment(32'h00010000, 32'hFFFF0000, 32'h7FFFFFFF);
    send_segment(32'h0, 32'h0, 32'hFFFE7FFF);
    send_segment(32'h1, 32'hFFFFFFFF, 32'h10000);
    drain();
    write_reg(pncm_pkg::REG_QUANT_STEP, 32'd0);
    send_segment(32'h00008000, 32'h00004000, 32'h0);
    send_segment(32'h00008000, 32'h00004000, 32'h0);
    drain();

    for (int phase = 0; phase < 5; phase++) begin
      case (phase)
        0: begin
          write_reg(pncm_pkg::REG_QUANT_STEP, 32'd655);
          write_reg(pncm_pkg::REG_CENTER_LIMIT, 32'hFFFE8000);
        end
        1: begin
          write_reg(pncm_pkg::REG_QUANT_STEP, 32'd65535);
          write_reg(pncm_pkg::REG_CENTER_LIMIT, 32'h80000000);
        end
        2: begin
          write_reg(pncm_pkg::REG_QUANT_STEP, 32'd1);
          write_reg(pncm_pkg::REG_CENTER_LIMIT, 32'h7FFFFFFF);
        end
        3: begin
          write_reg(pncm_pkg::REG_QUANT_STEP, 32'd3000);
          write_reg(pncm_pkg::REG_CENTER_LIMIT, 32'h0);
        end
        default: begin
          write_reg(pncm_pkg::REG_QUANT_STEP, 32'hFFFF);
          write_reg(pncm_pkg::REG_CENTER_LIMIT, 32'h0);
        end
      endcase
      case (phase % 4)
        0: idle_pct = 0;
        1: idle_pct = 45;
        2: idle_pct = 0;
        default: idle_pct = 12;
      endcase
      for (int n = 0; n < 240; n++) begin
        sx = pick_slope();
        sy = pick_slope();
        send_segment(sx, sy, $urandom_range(0, 1) ? $urandom() : 32'($urandom_range(0, 8)) - 32'd4);
      end
      drain();
    end

    repeat (50) @(negedge clk);
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    #50_000_000;
    $display("Regression FAIL");
    $finish;
  end
endmodule
